// File: sv/assert_macros.svh
// assertion macros shared by the stack machine rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("smc assertion failed");

// checked at every edge, reset included
`define SMC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("smc assertion failed");

`endif

// File: sv/smc_pkg.sv
// types, codes and sizes of the stack machine core
// no dependencies
package smc_pkg;

  localparam int WORD_W  = 64;
  localparam int DEPTH   = 256;            // power of two, ring pointers wrap naturally
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = PTR_W + 1;
  localparam int STEP_W  = $clog2(WORD_W);

  typedef enum logic [3:0] {
    K_PUSH = 4'd0, K_POP = 4'd1, K_REV = 4'd2, K_PNUM = 4'd3, K_PCHR = 4'd4,
    K_DUP = 4'd5, K_SWAP = 4'd6, K_SUB = 4'd7, K_SUM = 4'd8, K_MUL = 4'd9,
    K_DIV = 4'd10, K_REM = 4'd11, K_PEEK = 4'd12, K_SIZE = 4'd13, K_CLEAR = 4'd14
  } kind_t;

  localparam logic [2:0] EM_NONE = 3'd0;
  localparam logic [2:0] EM_NUM  = 3'd1;
  localparam logic [2:0] EM_CHR  = 3'd2;
  localparam logic [2:0] EM_PEEK = 3'd3;
  localparam logic [2:0] EM_SIZE = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_DIVZ  = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_HALT  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_LAT, S_EXEC, S_WR2, S_ITER, S_WRR, S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic              is_div;
    logic [WORD_W-1:0] opa;
    logic [WORD_W-1:0] opb;
  } alu_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] quo;   // quotient, or shifted multiplicand
    logic [WORD_W-1:0] acc;   // remainder, or product
  } alu_rsp_t;

endpackage

// File: sv/smc_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module smc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/smc_alu.sv
// iterative multiply (shift-add) and unsigned divide (restoring), one bit per cycle
// depends on smc_pkg
module smc_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  smc_pkg::alu_req_t  req,
  output smc_pkg::alu_rsp_t  rsp
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic                         div_r, div_nxt;
  logic [smc_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [smc_pkg::WORD_W-1:0]   q_r, q_nxt;
  logic [smc_pkg::WORD_W-1:0]   d_r, d_nxt;
  logic [smc_pkg::WORD_W-1:0]   acc_r, acc_nxt;
  logic [smc_pkg::WORD_W:0]     trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    div_nxt  = div_r;
    step_nxt = step_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    acc_nxt  = acc_r;
    trial    = {acc_r, q_r[smc_pkg::WORD_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      div_nxt  = req.is_div;
      step_nxt = '0;
      q_nxt    = req.opa;
      d_nxt    = req.opb;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (div_r) begin
        if (trial >= {1'b0, d_r}) begin
          acc_nxt = smc_pkg::WORD_W'(trial - {1'b0, d_r});
          q_nxt   = {q_r[smc_pkg::WORD_W-2:0], 1'b1};
        end else begin
          acc_nxt = trial[smc_pkg::WORD_W-1:0];
          q_nxt   = {q_r[smc_pkg::WORD_W-2:0], 1'b0};
        end
      end else begin
        if (d_r[0]) begin
          acc_nxt = acc_r + q_r;
        end
        q_nxt = {q_r[smc_pkg::WORD_W-2:0], 1'b0};
        d_nxt = {1'b0, d_r[smc_pkg::WORD_W-1:1]};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == smc_pkg::STEP_W'(smc_pkg::WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    div_r  <= div_nxt;
    step_r <= step_nxt;
    q_r    <= q_nxt;
    d_r    <= d_nxt;
    acc_r  <= acc_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
  assign rsp.acc  = acc_r;

endmodule

// File: sv/stack_machine_core.sv
// stack machine core: one instruction per transfer on a ring stack held in a ram
// steps: rda, rdb, lat, exec, then wr2 for swap or iter and wrr for mul, div and rem, then done
// one instruction at a time: the next transfer is taken only in idle, after the result has gone to the output register
// reset clears the entry count, base pointer, reversed and halted flags; stack ram is not cleared
// depends on smc_pkg, smc_ram, smc_alu, assert_macros.svh
`include "assert_macros.svh"

module stack_machine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // push_value[63:0]
  input  logic [3:0]  in_tuser,   // kind[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // result_value[63:0], status[66:64], entries[75:67], zero pad
  output logic [2:0]  out_tuser   // emit_kind[2:0]
);

  localparam int W = smc_pkg::WORD_W;
  localparam int P = smc_pkg::PTR_W;
  localparam int C = smc_pkg::CNT_W;

  smc_pkg::state_t state_r, state_nxt;

  logic [3:0]   kind_r, kind_nxt;
  logic [W-1:0] pval_r, pval_nxt;
  logic [W-1:0] a_r, a_nxt;
  logic [W-1:0] b_r, b_nxt;
  logic [C-1:0] cnt_r, cnt_nxt;
  logic [P-1:0] bp_r, bp_nxt;
  logic         rev_r, rev_nxt;
  logic         halted_r, halted_nxt;
  logic [P-1:0] wa_r, wa_nxt;
  logic [W-1:0] wd_r, wd_nxt;
  logic [W-1:0] val_r, val_nxt;
  logic [2:0]   emit_r, emit_nxt;
  logic [2:0]   stat_r, stat_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] oval_r, oval_nxt;
  logic [2:0]   oemit_r, oemit_nxt;
  logic [2:0]   ostat_r, ostat_nxt;
  logic [C-1:0] oent_r, oent_nxt;

  logic         go_wr2, go_iter, out_load;
  logic         ram_we;
  logic [P-1:0] ram_wa, ram_ra;
  logic [W-1:0] ram_wd, ram_rd;
  logic [P-1:0] top_slot, sec_slot;
  logic [W-1:0] ma, mb, alu_res;
  smc_pkg::alu_req_t alu_req;
  smc_pkg::alu_rsp_t alu_rsp;

  smc_ram #(.WIDTH(W), .DEPTH(smc_pkg::DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  smc_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  // ring slots of the top entry and the one below it
  assign top_slot = rev_r ? bp_r : P'(bp_r + cnt_r[P-1:0] - 1'b1);
  assign sec_slot = rev_r ? P'(bp_r + 1'b1) : P'(bp_r + cnt_r[P-1:0] - 2'd2);
  assign ram_ra   = (state_r == smc_pkg::S_RDB) ? sec_slot : top_slot;

  assign ma = a_r[W-1] ? W'(-a_r) : a_r;
  assign mb = b_r[W-1] ? W'(-b_r) : b_r;

  always_comb begin
    case (kind_r)
      smc_pkg::K_MUL: alu_res = alu_rsp.acc;
      smc_pkg::K_DIV: alu_res = (a_r[W-1] != b_r[W-1]) ? W'(-alu_rsp.quo) : alu_rsp.quo;
      default:        alu_res = a_r[W-1] ? W'(-alu_rsp.acc) : alu_rsp.acc;
    endcase
  end

  assign alu_req.start  = go_iter;
  assign alu_req.is_div = (kind_r != smc_pkg::K_MUL);
  assign alu_req.opa    = alu_req.is_div ? ma : a_r;
  assign alu_req.opb    = alu_req.is_div ? mb : b_r;

  assign in_tready = (state_r == smc_pkg::S_IDLE);
  assign out_load  = (state_r == smc_pkg::S_DONE) && (!out_valid_r || out_tready);

  // datapath and instruction execution
  always_comb begin
    kind_nxt   = kind_r;
    pval_nxt   = pval_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    cnt_nxt    = cnt_r;
    bp_nxt     = bp_r;
    rev_nxt    = rev_r;
    halted_nxt = halted_r;
    wa_nxt     = wa_r;
    wd_nxt     = wd_r;
    val_nxt    = val_r;
    emit_nxt   = emit_r;
    stat_nxt   = stat_r;
    go_wr2     = 1'b0;
    go_iter    = 1'b0;
    ram_we     = 1'b0;
    ram_wa     = wa_r;
    ram_wd     = wd_r;

    case (state_r)
      smc_pkg::S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt = in_tuser;
          pval_nxt = in_tdata;
        end
      end
      smc_pkg::S_RDB: a_nxt = ram_rd;
      smc_pkg::S_LAT: b_nxt = ram_rd;
      smc_pkg::S_EXEC: begin
        val_nxt  = '0;
        emit_nxt = smc_pkg::EM_NONE;
        stat_nxt = smc_pkg::ST_OK;
        if (halted_r) begin
          stat_nxt = smc_pkg::ST_HALT;
        end else begin
          case (kind_r)
            smc_pkg::K_PUSH, smc_pkg::K_DUP: begin
              if (cnt_r == C'(smc_pkg::DEPTH)) begin
                stat_nxt = smc_pkg::ST_FULL;
              end else if (kind_r == smc_pkg::K_DUP && cnt_r == '0) begin
                stat_nxt = smc_pkg::ST_UNDER;
              end else begin
                ram_we  = 1'b1;
                ram_wa  = rev_r ? P'(bp_r - 1'b1) : P'(bp_r + cnt_r[P-1:0]);
                ram_wd  = (kind_r == smc_pkg::K_PUSH) ? pval_r : a_r;
                bp_nxt  = rev_r ? P'(bp_r - 1'b1) : bp_r;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            smc_pkg::K_REV: begin
              if (cnt_r >= C'(2)) begin
                rev_nxt = !rev_r;
              end
            end
            smc_pkg::K_POP, smc_pkg::K_PNUM, smc_pkg::K_PCHR, smc_pkg::K_PEEK: begin
              if (cnt_r == '0) begin
                stat_nxt = smc_pkg::ST_UNDER;
              end else begin
                if (kind_r == smc_pkg::K_PNUM) begin
                  val_nxt  = a_r;
                  emit_nxt = smc_pkg::EM_NUM;
                end
                if (kind_r == smc_pkg::K_PCHR) begin
                  val_nxt  = {{(W-8){1'b0}}, a_r[7:0]};
                  emit_nxt = smc_pkg::EM_CHR;
                end
                if (kind_r == smc_pkg::K_PEEK) begin
                  val_nxt  = a_r;
                  emit_nxt = smc_pkg::EM_PEEK;
                end else begin
                  bp_nxt  = rev_r ? P'(bp_r + 1'b1) : bp_r;
                  cnt_nxt = cnt_r - 1'b1;
                end
              end
            end
            smc_pkg::K_SWAP, smc_pkg::K_SUB, smc_pkg::K_SUM, smc_pkg::K_MUL,
            smc_pkg::K_DIV, smc_pkg::K_REM: begin
              if (cnt_r < C'(2)) begin
                stat_nxt = smc_pkg::ST_UNDER;
              end else if ((kind_r == smc_pkg::K_DIV || kind_r == smc_pkg::K_REM)
                           && b_r == '0) begin
                stat_nxt = smc_pkg::ST_DIVZ;
              end else if (kind_r == smc_pkg::K_SWAP) begin
                ram_we = 1'b1;
                ram_wa = top_slot;
                ram_wd = b_r;
                wa_nxt = sec_slot;
                wd_nxt = a_r;
                go_wr2 = 1'b1;
              end else begin
                // the result lands in the slot below the old top
                bp_nxt  = rev_r ? P'(bp_r + 1'b1) : bp_r;
                cnt_nxt = cnt_r - 1'b1;
                wa_nxt  = sec_slot;
                if (kind_r == smc_pkg::K_SUB || kind_r == smc_pkg::K_SUM) begin
                  ram_we = 1'b1;
                  ram_wa = sec_slot;
                  ram_wd = (kind_r == smc_pkg::K_SUB) ? W'(a_r - b_r) : W'(a_r + b_r);
                end else begin
                  go_iter = 1'b1;
                end
              end
            end
            smc_pkg::K_SIZE: begin
              val_nxt  = W'(cnt_r);
              emit_nxt = smc_pkg::EM_SIZE;
            end
            smc_pkg::K_CLEAR: begin
              cnt_nxt = '0;
              bp_nxt  = '0;
              rev_nxt = 1'b0;
            end
            default: ;
          endcase
          if (stat_nxt != smc_pkg::ST_OK) begin
            halted_nxt = 1'b1;
          end
        end
      end
      smc_pkg::S_WR2: ram_we = 1'b1;
      smc_pkg::S_WRR: begin
        ram_we = 1'b1;
        ram_wd = alu_res;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smc_pkg::S_IDLE: if (in_tvalid) state_nxt = smc_pkg::S_RDA;
      smc_pkg::S_RDA:  state_nxt = smc_pkg::S_RDB;
      smc_pkg::S_RDB:  state_nxt = smc_pkg::S_LAT;
      smc_pkg::S_LAT:  state_nxt = smc_pkg::S_EXEC;
      smc_pkg::S_EXEC: begin
        if (go_wr2) begin
          state_nxt = smc_pkg::S_WR2;
        end else if (go_iter) begin
          state_nxt = smc_pkg::S_ITER;
        end else begin
          state_nxt = smc_pkg::S_DONE;
        end
      end
      smc_pkg::S_WR2:  state_nxt = smc_pkg::S_DONE;
      smc_pkg::S_ITER: if (alu_rsp.done) state_nxt = smc_pkg::S_WRR;
      smc_pkg::S_WRR:  state_nxt = smc_pkg::S_DONE;
      smc_pkg::S_DONE: if (out_load) state_nxt = smc_pkg::S_IDLE;
      default:         state_nxt = smc_pkg::S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    oval_nxt      = oval_r;
    oemit_nxt     = oemit_r;
    ostat_nxt     = ostat_r;
    oent_nxt      = oent_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      oval_nxt      = val_r;
      oemit_nxt     = emit_r;
      ostat_nxt     = stat_r;
      oent_nxt      = cnt_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smc_pkg::S_IDLE;
      cnt_r       <= '0;
      bp_r        <= '0;
      rev_r       <= 1'b0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bp_r        <= bp_nxt;
      rev_r       <= rev_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r  <= kind_nxt;
    pval_r  <= pval_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    wa_r    <= wa_nxt;
    wd_r    <= wd_nxt;
    val_r   <= val_nxt;
    emit_r  <= emit_nxt;
    stat_r  <= stat_nxt;
    oval_r  <= oval_nxt;
    oemit_r <= oemit_nxt;
    ostat_r <= ostat_nxt;
    oent_r  <= oent_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = oemit_r;
  assign out_tdata  = {4'b0, oent_r, ostat_r, oval_r};

  `SMC_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> (!out_valid_r && state_r == smc_pkg::S_IDLE))
  `SMC_ASSERT(a_cnt_bound, cnt_r <= C'(smc_pkg::DEPTH))
  `SMC_ASSERT(a_halt_sticky, halted_r |=> halted_r)
  `SMC_ASSERT(a_alu_in_iter, alu_rsp.busy |-> (state_r == smc_pkg::S_ITER))
  `SMC_ASSERT(a_halt_status, (out_valid_r && ostat_r == smc_pkg::ST_HALT) |-> halted_r)

endmodule

// File: bench/smc_checker.sv
// checker for the stack machine core: watches both stream channels, predicts each result
// from its own copy of the stack and compares; depends on smc_pkg
module smc_checker
  import smc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [3:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  input  logic [2:0]  out_tuser,
  output int          err_count,
  output int          pending
);

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  emit;
    logic [2:0]  status;
    logic [8:0]  entries;
  } answer_t;

  logic [63:0] ram [DEPTH];
  int unsigned cnt, base;
  bit          rev, halt;
  answer_t     answers [$];

  assign pending = answers.size();

  function automatic int unsigned top_slot(int unsigned i);
    if (rev) return (base + i) % DEPTH;
    return (base + cnt - 1 - i) % DEPTH;
  endfunction

  function automatic void push_word(logic [63:0] v);
    if (rev) begin
      base = (base + DEPTH - 1) % DEPTH;
      ram[base] = v;
    end else begin
      ram[(base + cnt) % DEPTH] = v;
    end
    cnt++;
  endfunction

  function automatic void pop_word();
    if (rev) base = (base + 1) % DEPTH;
    cnt--;
  endfunction

  function automatic answer_t execute(logic [3:0] kind, logic [63:0] pv);
    answer_t     r;
    logic [63:0] a, b, res, ma, mb;
    r = '0;
    if (halt) begin
      r.status = ST_HALT;
    end else if (kind == K_PUSH || kind == K_DUP) begin
      if (cnt >= DEPTH) r.status = ST_FULL;
      else if (kind == K_DUP && cnt < 1) r.status = ST_UNDER;
      else push_word(kind == K_PUSH ? pv : ram[top_slot(0)]);
    end else if (kind == K_REV) begin
      if (cnt >= 2) rev = !rev;
    end else if (kind == K_POP || kind == K_PNUM || kind == K_PCHR || kind == K_PEEK) begin
      if (cnt < 1) begin
        r.status = ST_UNDER;
      end else begin
        a = ram[top_slot(0)];
        if (kind == K_PNUM) begin r.value = a; r.emit = EM_NUM; end
        if (kind == K_PCHR) begin r.value = {56'd0, a[7:0]}; r.emit = EM_CHR; end
        if (kind == K_PEEK) begin r.value = a; r.emit = EM_PEEK; end
        if (kind != K_PEEK) pop_word();
      end
    end else if (kind >= K_SWAP && kind <= K_REM) begin
      if (cnt < 2) begin
        r.status = ST_UNDER;
      end else begin
        a = ram[top_slot(0)];
        b = ram[top_slot(1)];
        if ((kind == K_DIV || kind == K_REM) && b == 0) begin
          r.status = ST_DIVZ;
        end else if (kind == K_SWAP) begin
          ram[top_slot(0)] = b;
          ram[top_slot(1)] = a;
        end else begin
          ma = a[63] ? -a : a;
          mb = b[63] ? -b : b;
          case (kind)
            K_SUB: res = a - b;
            K_SUM: res = a + b;
            K_MUL: res = a * b;
            K_DIV: begin
              res = ma / mb;
              if (a[63] != b[63]) res = -res;
            end
            default: begin
              res = ma % mb;
              if (a[63]) res = -res;
            end
          endcase
          pop_word();
          ram[top_slot(0)] = res;
        end
      end
    end else if (kind == K_SIZE) begin
      r.value = 64'(cnt);
      r.emit  = EM_SIZE;
    end else if (kind == K_CLEAR) begin
      cnt = 0; base = 0; rev = 0;
    end
    if (r.status inside {ST_UNDER, ST_DIVZ, ST_FULL}) halt = 1;
    r.entries = 9'(cnt);
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t want, got;
    if (!rst_n) begin
      cnt <= 0; base <= 0; rev <= 0; halt <= 0;
      answers.delete();
      err_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[63:0], out_tuser, out_tdata[66:64], out_tdata[75:67]};
        if (answers.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          err_count <= err_count + 1;
        end else begin
          want = answers.pop_front();
          if (got !== want || out_tdata[79:76] !== 4'd0) begin
            $display("%0t: mismatch, expected val=%h emit=%0d st=%0d n=%0d, actual val=%h emit=%0d st=%0d n=%0d",
                     $time, want.value, want.emit, want.status, want.entries,
                     got.value, got.emit, got.status, got.entries);
            err_count <= err_count + 1;
          end
        end
      end
      // prediction after the compare so a same-edge transfer cannot be matched early
      if (in_tvalid && in_tready) answers.push_back(execute(in_tuser, in_tdata));
    end
  end

endmodule

// File: bench/tb_stack_machine_core.sv
// testbench top for stack_machine_core: drives instruction transfers and result backpressure,
// gives the verdict; depends on smc_pkg, smc_checker and the core rtl
module tb_stack_machine_core;
  import smc_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [63:0] in_tdata;
  logic [3:0]  in_tuser;
  logic        out_tvalid, out_tready;
  logic [79:0] out_tdata;
  logic [2:0]  out_tuser;
  int          err_count, pending;
  bit          quiet;      // no idling in the last part
  bit          long_hold;  // request for a long receiver stall
  int          stuck;

  stack_machine_core uut (.*);

  smc_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver side: random stall bursts, one long hold-off on request
  initial begin
    int n;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 9) < 3) begin
        n = $urandom_range(1, 13);
        out_tready <= 0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck > IDLE_LIMIT) begin
      $display("tb_stack_machine_core NOT OK");
      $finish;
    end
  end

  task automatic send(logic [3:0] kind, logic [63:0] v);
    in_tvalid <= 1;
    in_tuser  <= kind;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!quiet && $urandom_range(0, 9) < 2) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // restart after the core halts; reset may be asserted only once, so clear instead
  // is not enough: a halt needs the run to continue with halted answers until end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return -64'(int'($urandom_range(0, 20)));
      3: return 64'($urandom_range(0, 300));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // legal instruction given a tracked depth, avoids halting
  task automatic random_legal(inout int depth);
    int k;
    k = $urandom_range(0, 14);
    if (depth < 2 && k >= K_SWAP && k <= K_REM) k = K_PUSH;
    if (depth < 1 && (k == K_POP || k == K_PNUM || k == K_PCHR || k == K_DUP || k == K_PEEK))
      k = K_PUSH;
    if (depth >= DEPTH && (k == K_PUSH || k == K_DUP)) k = K_POP;
    if (depth >= DEPTH && (k == K_DIV || k == K_REM)) k = K_SUB;
    if (k == K_CLEAR && $urandom_range(0, 3) != 0) k = K_SIZE;
    if (k == K_DIV || k == K_REM) begin
      // make sure the right operand is nonzero: push a fresh nonzero word and swap it below the top
      send(K_PUSH, rand_word() | 64'd1); depth++;
      send(K_SWAP, 0);
    end
    send(kind_t'(k), rand_word());
    case (k)
      K_PUSH, K_DUP: depth++;
      K_POP, K_PNUM, K_PCHR, K_SUB, K_SUM, K_MUL, K_DIV, K_REM: depth--;
      K_CLEAR: depth = 0;
      default: ;
    endcase
  endtask

  initial begin
    int depth, i;
    rst_n = 0; in_tvalid = 0; in_tdata = 0; in_tuser = 0;
    quiet = 0; long_hold = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, every operation but pop, short reverse, division overflow
    send(K_REV, 0);
    send(K_SIZE, 0);
    send(K_PUSH, 64'hffff_ffff_ffff_ffff);
    send(K_REV, 0);
    send(K_PUSH, 64'h8000_0000_0000_0000);
    send(K_DIV, 0);
    send(K_PUSH, 64'h8000_0000_0000_0000);
    send(K_PUSH, 64'hffff_ffff_ffff_ffff);
    send(K_SWAP, 0);
    send(K_REM, 0);
    send(K_PUSH, 64'h7fff_ffff_ffff_ff41);
    send(K_DUP, 0);
    send(K_MUL, 0);
    send(K_PUSH, -64'sd7);
    send(K_REV, 0);
    send(K_SUB, 0);
    send(K_SUM, 0);
    send(K_PEEK, 0);
    send(K_PCHR, 0);
    send(K_PNUM, 0);
    send(4'hf, 64'h1234);
    send(K_CLEAR, 0);
    drain();
    // long receiver stall while the sender keeps offering
    long_hold = 1;
    depth = 0;
    for (i = 0; i < 40; i++) random_legal(depth);
    drain();
    // fill to full, reverse at depth, then overflow check later
    for (i = 0; i < DEPTH; i++) send(K_PUSH, rand_word());
    send(K_REV, 0);
    depth = DEPTH;
    for (i = 0; i < 200; i++) begin
      if (i == 170) quiet = 1;
      random_legal(depth);
    end
    // fill and error paths, then halted answers
    while (depth < DEPTH) begin send(K_PUSH, rand_word()); depth++; end
    send(K_DUP, 0);
    for (i = 0; i < 5; i++) send(kind_t'($urandom_range(0, 15)), rand_word());
    drain();
    if (err_count == 0) begin
      $display("tb_stack_machine_core OK");
    end else begin
      $display("tb_stack_machine_core NOT OK");
    end
    $finish;
  end

endmodule
